/* src/rgb_frame_to_lcd_byte_stream_macros.svh */
// assertion macros shared by the lcd byte stream block
// expects clk and rst_n in the scope of each use
`ifndef RGB_FRAME_TO_LCD_BYTE_STREAM_MACROS_SVH
`define RGB_FRAME_TO_LCD_BYTE_STREAM_MACROS_SVH

// property holds on every edge outside reset
`define RFL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent implies consequent in the next cycle
`define RFL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/rfl_pkg.sv */
// types, constants and byte selection for the lcd byte stream block
// no dependencies
`timescale 1ns / 1ps

package rfl_pkg;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_data;
    logic       last_of_run;
  } beat_t;

  typedef struct packed {
    logic [8:0] width;
    logic [7:0] height;
  } cfg_t;

  typedef struct packed {
    logic        hdr;
    logic [15:0] color;
  } q_entry_t;

  localparam int COUNT_W = 17;

  localparam logic [8:0] WIDTH_RST  = 9'd320;
  localparam logic [7:0] HEIGHT_RST = 8'd240;

  localparam logic [7:0] RB_MASK = 8'hF8;
  localparam logic [7:0] G_MASK  = 8'hFC;

  localparam logic [7:0] CMD_COL_SET = 8'h2A;
  localparam logic [7:0] CMD_PAGE_SET = 8'h2B;
  localparam logic [7:0] CMD_MEM_WRITE = 8'h2C;

  // register indexes
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef logic [3:0] step_t;

  localparam step_t STEP_COL_CMD   = 4'd0;
  localparam step_t STEP_COL_S_HI  = 4'd1;
  localparam step_t STEP_COL_S_LO  = 4'd2;
  localparam step_t STEP_COL_E_HI  = 4'd3;
  localparam step_t STEP_COL_E_LO  = 4'd4;
  localparam step_t STEP_PAGE_CMD  = 4'd5;
  localparam step_t STEP_PAGE_S_HI = 4'd6;
  localparam step_t STEP_PAGE_S_LO = 4'd7;
  localparam step_t STEP_PAGE_E_HI = 4'd8;
  localparam step_t STEP_PAGE_E_LO = 4'd9;
  localparam step_t STEP_MEM_CMD   = 4'd10;
  localparam step_t STEP_PIX_HI    = 4'd11;
  localparam step_t STEP_PIX_LO    = 4'd12;

  function automatic logic [15:0] rgb565(input pixel_t p);
    logic [7:0] rc;
    logic [7:0] gc;
    rc = p.red & RB_MASK;
    gc = p.green & G_MASK;
    return {rc[7:3], gc[7:2], p.blue[7:3]};
  endfunction

  function automatic beat_t step_beat(input step_t step, input logic [15:0] color,
                                      input logic [15:0] col_end,
                                      input logic [15:0] page_end);
    beat_t b;
    b.out_byte    = 8'h00;
    b.is_data     = 1'b1;
    b.last_of_run = 1'b0;
    case (step)
      STEP_COL_CMD: begin
        b.out_byte = CMD_COL_SET;
        b.is_data  = 1'b0;
      end
      STEP_COL_E_HI:  b.out_byte = col_end[15:8];
      STEP_COL_E_LO:  b.out_byte = col_end[7:0];
      STEP_PAGE_CMD: begin
        b.out_byte = CMD_PAGE_SET;
        b.is_data  = 1'b0;
      end
      STEP_PAGE_E_HI: b.out_byte = page_end[15:8];
      STEP_PAGE_E_LO: b.out_byte = page_end[7:0];
      STEP_MEM_CMD: begin
        b.out_byte = CMD_MEM_WRITE;
        b.is_data  = 1'b0;
      end
      STEP_PIX_HI:    b.out_byte = color[15:8];
      STEP_PIX_LO: begin
        b.out_byte    = color[7:0];
        b.last_of_run = 1'b1;
      end
      default:        b.out_byte = 8'h00;
    endcase
    return b;
  endfunction

endpackage

/* src/rfl_front.sv */
// front end: takes pixels, converts to rgb565 and tracks the frame position
// depends on rfl_pkg
`timescale 1ns / 1ps

module rfl_front (
  input  logic               clk,
  input  logic               rst_n,
  input  rfl_pkg::cfg_t      cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  rfl_pkg::pixel_t    in_pixel,
  input  logic               q_full,
  output logic               q_push,
  output rfl_pkg::q_entry_t  q_wdata
);
  import rfl_pkg::*;

  logic [COUNT_W-1:0] pixel_count_r, pixel_count_nxt;
  logic [COUNT_W-1:0] frame_len;
  logic [COUNT_W:0]   count_inc;

  assign in_ready      = !q_full;
  assign q_push        = in_valid && in_ready;
  assign q_wdata.hdr   = (pixel_count_r == '0);
  assign q_wdata.color = rgb565(in_pixel);

  assign frame_len = {8'd0, cfg.width} * {9'd0, cfg.height};
  assign count_inc = {1'b0, pixel_count_r} + 1'b1;

  always_comb begin
    pixel_count_nxt = pixel_count_r;
    if (q_push) begin
      if (count_inc >= {1'b0, frame_len}) begin
        pixel_count_nxt = '0;
      end else begin
        pixel_count_nxt = count_inc[COUNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_count_r <= '0;
    end else begin
      pixel_count_r <= pixel_count_nxt;
    end
  end

endmodule

/* src/rfl_queue.sv */
// small first-word-fall-through queue between front and back end
// depends on rfl_pkg
`timescale 1ns / 1ps

module rfl_queue #(
  parameter int DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  rfl_pkg::q_entry_t  wdata,
  output logic               full,
  input  logic               pop,
  output logic               valid,
  output rfl_pkg::q_entry_t  rdata
);
  import rfl_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  q_entry_t           mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign valid = (count_r != '0);
  assign rdata = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

/* src/rfl_back.sv */
// back end: steps through header and pixel bytes into the output register
// depends on rfl_pkg and the assertion macro header
`timescale 1ns / 1ps

`include "rgb_frame_to_lcd_byte_stream_macros.svh"

module rfl_back (
  input  logic               clk,
  input  logic               rst_n,
  input  rfl_pkg::cfg_t      cfg,
  input  logic               q_valid,
  input  rfl_pkg::q_entry_t  q_rdata,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output rfl_pkg::beat_t     out_beat
);
  import rfl_pkg::*;

  logic        busy_r, busy_nxt;
  step_t       step_r, step_nxt;
  step_t       cur_step;
  logic        out_valid_r, out_valid_nxt;
  beat_t       out_beat_r;
  beat_t       beat;
  logic        load;
  logic [15:0] col_end;
  logic [15:0] page_end;

  assign col_end  = {7'd0, cfg.width} - 16'd1;
  assign page_end = {8'd0, cfg.height} - 16'd1;

  assign cur_step = busy_r ? step_r : (q_rdata.hdr ? STEP_COL_CMD : STEP_PIX_HI);
  assign beat     = step_beat(cur_step, q_rdata.color, col_end, page_end);
  assign load     = q_valid && (!out_valid_r || out_ready);
  assign q_pop    = load && (cur_step == STEP_PIX_LO);

  always_comb begin
    busy_nxt      = busy_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (load) begin
      out_valid_nxt = 1'b1;
      if (cur_step == STEP_PIX_LO) begin
        busy_nxt = 1'b0;
      end else begin
        busy_nxt = 1'b1;
        step_nxt = cur_step + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    if (load) begin
      out_beat_r <= beat;
    end
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

  `RFL_ASSERT(a_busy_has_entry, !busy_r || q_valid, "sequencer busy with empty queue")
  `RFL_ASSERT(a_step_range, !busy_r || (step_r <= STEP_PIX_LO), "step beyond pixel low byte")
  `RFL_ASSERT_NEXT(a_pop_marks_last, q_pop, out_valid_r && out_beat_r.last_of_run,
                   "entry popped without a last beat")

endmodule

/* src/rgb_frame_to_lcd_byte_stream.sv */
// channel   handshake          payload
// in_       in_valid/in_ready  in_pixel: red, green, blue
// out_      out_valid/out_ready out_beat: out_byte, is_data, last_of_run
// cfg       apb psel/penable   frame_width @0x0, frame_height @0x4
// one output byte per cycle while out_ready is high and the queue holds an entry: a pixel gives
// 2 bytes, 13 on the first of a frame; the byte sequencer in the back end sets that sequence; the front runs ahead
// by the queue depth, so input stalls only once the queue is full
// synchronous reset clears the counter, queue and output valid; registers
// return to 320 x 240
`timescale 1ns / 1ps

module rgb_frame_to_lcd_byte_stream #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  rfl_pkg::pixel_t  in_pixel,
  output logic             out_valid,
  input  logic             out_ready,
  output rfl_pkg::beat_t   out_beat,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import rfl_pkg::*;

  cfg_t      cfg_r, cfg_nxt;
  logic      wr_en;
  logic      q_full;
  logic      q_push;
  logic      q_pop;
  logic      q_valid;
  q_entry_t  q_wdata;
  q_entry_t  q_rdata;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[1:0] == 2'b00);

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (paddr[2])
        REG_WIDTH:  cfg_nxt.width  = pwdata[8:0];
        REG_HEIGHT: cfg_nxt.height = pwdata[7:0];
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width  <= WIDTH_RST;
      cfg_r.height <= HEIGHT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr[1:0] == 2'b00) begin
      case (paddr[2])
        REG_WIDTH:  prdata = {23'd0, cfg_r.width};
        REG_HEIGHT: prdata = {24'd0, cfg_r.height};
        default:    prdata = 32'd0;
      endcase
    end
  end

  rfl_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_pixel (in_pixel),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  rfl_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (q_rdata)
  );

  rfl_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_beat  (out_beat)
  );

endmodule

/* test/lcd_stream_checker.sv */
// checker for the lcd byte stream block: tracks window registers from apb writes,
// predicts header and rgb565 beats per accepted pixel, compares output beats in order
// depends on rfl_pkg
`timescale 1ns / 1ps

module lcd_stream_checker (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  rfl_pkg::pixel_t  in_pixel,
  input  logic             out_valid,
  input  logic             out_ready,
  input  rfl_pkg::beat_t   out_beat,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic             pready,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output int               fail_count,
  output int               pending_beats
);
  import rfl_pkg::*;

  logic [8:0]  col_count;
  logic [7:0]  row_count;
  logic [16:0] frame_pos;
  beat_t       lcd_beats_q[$];

  function automatic beat_t make_beat(logic [7:0] value, logic data_flag, logic last_flag);
    beat_t b;
    b.out_byte    = value;
    b.is_data     = data_flag;
    b.last_of_run = last_flag;
    return b;
  endfunction

  function automatic void push_window(logic [7:0] cmd, logic [15:0] win_end);
    lcd_beats_q.push_back(make_beat(cmd, 1'b0, 1'b0));
    lcd_beats_q.push_back(make_beat(8'h00, 1'b1, 1'b0));
    lcd_beats_q.push_back(make_beat(8'h00, 1'b1, 1'b0));
    lcd_beats_q.push_back(make_beat(win_end[15:8], 1'b1, 1'b0));
    lcd_beats_q.push_back(make_beat(win_end[7:0], 1'b1, 1'b0));
  endfunction

  function automatic void predict_pixel_beats(pixel_t p);
    logic [15:0] color;
    logic [16:0] frame_len;
    color     = {p.red[7:3], p.green[7:2], p.blue[7:3]};
    frame_len = 17'(col_count) * 17'(row_count);
    if (frame_pos == '0) begin
      push_window(CMD_COL_SET, 16'(col_count) - 16'd1);
      push_window(CMD_PAGE_SET, 16'(row_count) - 16'd1);
      lcd_beats_q.push_back(make_beat(CMD_MEM_WRITE, 1'b0, 1'b0));
    end
    lcd_beats_q.push_back(make_beat(color[15:8], 1'b1, 1'b0));
    lcd_beats_q.push_back(make_beat(color[7:0], 1'b1, 1'b1));
    if (32'(frame_pos) + 32'd1 >= 32'(frame_len)) begin
      frame_pos = '0;
    end else begin
      frame_pos = frame_pos + 17'd1;
    end
  endfunction

  always @(posedge clk) begin
    beat_t want;
    if (!rst_n) begin
      col_count  = WIDTH_RST;
      row_count  = HEIGHT_RST;
      frame_pos  = '0;
      fail_count = 0;
      lcd_beats_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_WIDTH) begin
          col_count = pwdata[8:0];
        end else begin
          row_count = pwdata[7:0];
        end
      end
      if (in_valid && in_ready) begin
        predict_pixel_beats(in_pixel);
      end
      if (out_valid && out_ready) begin
        if (lcd_beats_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("%0t: unexpected beat byte %02h data %0b last %0b", $time,
                     out_beat.out_byte, out_beat.is_data, out_beat.last_of_run);
          end
        end else begin
          want = lcd_beats_q.pop_front();
          if (out_beat.out_byte !== want.out_byte || out_beat.is_data !== want.is_data ||
              out_beat.last_of_run !== want.last_of_run) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("%0t: beat mismatch exp byte %02h data %0b last %0b, got %02h %0b %0b",
                       $time, want.out_byte, want.is_data, want.last_of_run,
                       out_beat.out_byte, out_beat.is_data, out_beat.last_of_run);
            end
          end
        end
      end
    end
    pending_beats = lcd_beats_q.size();
  end

endmodule

/* test/tb_rgb_frame_to_lcd_byte_stream.sv */
// top testbench for rgb_frame_to_lcd_byte_stream: clock, reset, pixel and apb stimulus,
// random stalls on both channels, watchdog and verdict
// depends on rfl_pkg, the block and lcd_stream_checker
`timescale 1ns / 1ps

module tb_rgb_frame_to_lcd_byte_stream;
  import rfl_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int PIXEL_TARGET = 320;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  pixel_t      in_pixel;
  logic        out_valid;
  logic        out_ready = 1'b0;
  beat_t       out_beat;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int fail_count;
  int pending_beats;
  int send_idle_pct = 37;
  int recv_idle_pct = 53;
  int pixels_sent   = 0;
  int quiet_cycles  = 0;

  rgb_frame_to_lcd_byte_stream u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_pixel  (in_pixel),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_beat  (out_beat),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  lcd_stream_checker u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_pixel      (in_pixel),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_beat      (out_beat),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .fail_count    (fail_count),
    .pending_beats (pending_beats)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles + 1 >= IDLE_LIMIT) begin
          $display("** rgb_frame_to_lcd_byte_stream: FAILED **");
          $finish;
        end
      end
    end
  end

  task automatic send_pixel(input pixel_t p);
    if (pixels_sent < 110) begin
      send_idle_pct = 37;
      recv_idle_pct = 53;
    end else if (pixels_sent < 220) begin
      send_idle_pct = 53;
      recv_idle_pct = 37;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_pixel <= p;
    do @(posedge clk); while (!in_ready);
    pixels_sent++;
  endtask

  task automatic drain;
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_beats != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_window(input logic [31:0] w, input logic [31:0] h);
    drain();
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
  endtask

  function automatic pixel_t rand_pixel();
    return pixel_t'(24'($urandom));
  endfunction

  function automatic int pick_extreme(input int lo_mid, input int hi_mid, input int top);
    case ($urandom_range(0, 3))
      0: return 0;
      1: return lo_mid;
      2: return hi_mid;
      default: return top;
    endcase
  endfunction

  initial begin
    int w;
    int h;
    int n;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_pixel = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // reset geometry, component extremes
    send_pixel(pixel_t'({8'hFF, 8'hFF, 8'hFF}));
    send_pixel(pixel_t'({8'h00, 8'h00, 8'h00}));
    // shrink mid frame: count already at the new length
    set_window(1, 2);
    send_pixel(pixel_t'({8'hAA, 8'h55, 8'hAA}));
    send_pixel(pixel_t'({8'h55, 8'hAA, 8'h55}));
    send_pixel(pixel_t'({8'hFF, 8'h00, 8'hFF}));
    // zero width and zero height, largest values in range
    set_window(0, 5);
    send_pixel(pixel_t'({8'h07, 8'h03, 8'hF8}));
    send_pixel(pixel_t'({8'hF8, 8'hFC, 8'h07}));
    set_window(511, 0);
    send_pixel(rand_pixel());
    send_pixel(rand_pixel());
    set_window(511, 255);
    send_pixel(rand_pixel());
    send_pixel(rand_pixel());
    // one pixel frames, walking bits
    set_window(1, 1);
    send_pixel(pixel_t'({8'h01, 8'h02, 8'h04}));
    send_pixel(pixel_t'({8'h08, 8'h10, 8'h20}));
    send_pixel(pixel_t'({8'h40, 8'h80, 8'h7F}));
    // upper write bits must be dropped
    set_window(32'hFFFF_FE03, 32'hFFFF_FF02);
    repeat (6) send_pixel(rand_pixel());

    while (pixels_sent < PIXEL_TARGET) begin
      if ($urandom_range(0, 9) < 9) begin
        w = $urandom_range(1, 6);
        h = $urandom_range(1, 4);
        n = $urandom_range(1, 3 * w * h);
      end else begin
        w = pick_extreme(1, 320, 511);
        h = pick_extreme(1, 240, 255);
        n = $urandom_range(1, 6);
      end
      set_window({23'($urandom), 9'(w)}, {24'($urandom), 8'(h)});
      repeat (n) send_pixel(rand_pixel());
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_beats != 0) @(negedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending_beats == 0) begin
      $display("** rgb_frame_to_lcd_byte_stream: PASSED **");
    end else begin
      $display("** rgb_frame_to_lcd_byte_stream: FAILED **");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+src
src/rfl_pkg.sv
src/rfl_front.sv
src/rfl_queue.sv
src/rfl_back.sv
src/rgb_frame_to_lcd_byte_stream.sv
test/lcd_stream_checker.sv
test/tb_rgb_frame_to_lcd_byte_stream.sv
